### src/lpfc_pkg.sv
package lpfc_pkg;

    // pipeline depth from input transfer to output register
    localparam int LAT      = 55;
    localparam int SQ_W     = 48;   // sum of squares
    localparam int N_W      = 24;   // integer norm
    localparam int REM_W    = 25;   // divider remainder
    localparam int Q_W      = 17;   // quotient, one bit above Q0.16
    localparam int ACC_W    = 32;   // Horner accumulator, Q30 signed
    localparam int U2_W     = 31;   // squared phase argument, Q30
    localparam int T_W      = 15;   // quarter-wave argument, Q14
    localparam int SIDE_W   = 17;   // quadrant and argument beside the Horner chain
    localparam int NUM_HORNER = 4;

    // stage offsets for the side lines
    localparam int TN_LINE  = 28;   // too-near flag after the prep stage
    localparam int TN_TAP   = 16;   // flag tap where the quotient appears
    localparam int RED_PAD  = 2;
    localparam int GRN_PAD  = 9;

    localparam logic [15:0] NEAR_RESET = 16'd3072;
    localparam logic        REG_NEAR   = 1'b0;   // register index 0

    // sine Taylor coefficients, Q30, highest power first at index 4
    localparam logic [4:0][31:0] SIN_COEF = {
        32'sd172272, -32'sd5026995, 32'sd85569306, -32'sd693598668, 32'sd1686629713
    };

endpackage

### src/lidar_point_false_color.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: column, row, pos_x, pos_y, pos_z
// m_*       out  m_tvalid/m_tready  m_tdata: column, row, red, green, blue; m_tuser: too_near
// apb       in   psel/penable       near_distance at byte address 0
//
// One point per cycle while the output register is not stalled.
// Most of the pipeline is the 24-cell square-root chain and the 17-cell divider chain.
// rst_n clears the valid line and loads near_distance with 3072 (3 m).
// When the output register holds a transfer that is not taken, the whole chain holds.
module lidar_point_false_color (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // column[11:0], row[17:12], pos_x[41:18], pos_y[65:42], pos_z[89:66]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // column[11:0], row[17:12], red[25:18], green[33:26], blue[42:34]
    output logic        m_tuser,   // too_near[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LAT = lpfc_pkg::LAT;

    logic adv;
    logic [LAT-1:0] vld_reg;
    logic [15:0]    near_reg;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lpfc_pkg::REG_NEAR) ? {16'd0, near_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= lpfc_pkg::NEAR_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == lpfc_pkg::REG_NEAR))
        begin
            near_reg <= pwdata[15:0];
        end
    end

    // advance the chain when the output register is free or taken
    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // pixel position line
    logic [17:0] cr_reg [LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cr_reg[0] <= s_tdata[17:0];
            for (int i = 1; i < LAT; i++)
            begin
                cr_reg[i] <= cr_reg[i-1];
            end
        end
    end

    // squares and their sum
    logic signed [23:0] px, py, pz;
    logic [46:0] sqx_reg, sqy_reg, sqz_reg;
    logic [lpfc_pkg::SQ_W-1:0] sum_reg;
    logic signed [47:0] sqx_full, sqy_full, sqz_full;

    assign px = $signed(s_tdata[41:18]);
    assign py = $signed(s_tdata[65:42]);
    assign pz = $signed(s_tdata[89:66]);
    assign sqx_full = px * px;
    assign sqy_full = py * py;
    assign sqz_full = pz * pz;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= sqx_full[46:0];
            sqy_reg <= sqy_full[46:0];
            sqz_reg <= sqz_full[46:0];
            sum_reg <= 48'(sqx_reg) + 48'(sqy_reg) + 48'(sqz_reg);
        end
    end

    // integer norm, one root bit per cell
    logic [lpfc_pkg::SQ_W-1:0] isq_v   [lpfc_pkg::N_W+1];
    logic [lpfc_pkg::SQ_W-1:0] isq_res [lpfc_pkg::N_W+1];

    assign isq_v[0]   = sum_reg;
    assign isq_res[0] = '0;

    for (genvar k = 0; k < lpfc_pkg::N_W; k++)
    begin : g_norm
        lpfc_isqrt_cell #(
            .W (lpfc_pkg::SQ_W),
            .B (lpfc_pkg::N_W - 1 - k)
        ) u_cell (
            .clk     (clk),
            .en      (adv),
            .v_in    (isq_v[k]),
            .res_in  (isq_res[k]),
            .v_out   (isq_v[k+1]),
            .res_out (isq_res[k+1])
        );
    end

    // compare against near distance, set up the numerator
    logic [lpfc_pkg::N_W-1:0] norm;
    logic                     tn_next;
    logic                     tn_reg;
    logic [lpfc_pkg::N_W-1:0] d0_reg;
    logic [lpfc_pkg::N_W-1:0] den_reg;

    assign norm    = isq_res[lpfc_pkg::N_W][lpfc_pkg::N_W-1:0];
    assign tn_next = (norm <= 24'(near_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tn_reg  <= tn_next;
            d0_reg  <= tn_next ? '0 : (norm - 24'(near_reg));
            den_reg <= norm;
        end
    end

    // too-near flag line
    logic tn_line_reg [lpfc_pkg::TN_LINE];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tn_line_reg[0] <= tn_reg;
            for (int i = 1; i < lpfc_pkg::TN_LINE; i++)
            begin
                tn_line_reg[i] <= tn_line_reg[i-1];
            end
        end
    end

    // range quotient, one bit per cell
    logic [lpfc_pkg::REM_W-1:0] dv_rem [lpfc_pkg::Q_W+1];
    logic [lpfc_pkg::N_W-1:0]   dv_den [lpfc_pkg::Q_W+1];
    logic [lpfc_pkg::Q_W-1:0]   dv_q   [lpfc_pkg::Q_W+1];

    assign dv_rem[0] = {1'b0, d0_reg};
    assign dv_den[0] = den_reg;
    assign dv_q[0]   = '0;

    for (genvar k = 0; k < lpfc_pkg::Q_W; k++)
    begin : g_div
        lpfc_div_cell #(
            .W     (lpfc_pkg::REM_W),
            .QW    (lpfc_pkg::Q_W),
            .SHIFT (k != 0)
        ) u_cell (
            .clk     (clk),
            .en      (adv),
            .rem_in  (dv_rem[k]),
            .den_in  (dv_den[k]),
            .q_in    (dv_q[k]),
            .rem_out (dv_rem[k+1]),
            .den_out (dv_den[k+1]),
            .q_out   (dv_q[k+1])
        );
    end

    // saturate to Q0.16, zero when too near
    logic [15:0] rng;
    logic [lpfc_pkg::Q_W-1:0] quot;

    assign quot = dv_q[lpfc_pkg::Q_W];
    assign rng  = tn_line_reg[lpfc_pkg::TN_TAP] ? 16'd0 :
                  (quot[16] ? 16'hFFFF : quot[15:0]);

    // red: root of 65025*range, top byte
    logic [31:0] rv_reg;
    logic [15:0] rd_v   [9];
    logic [15:0] rd_res [9];
    logic [7:0]  red_line_reg [lpfc_pkg::RED_PAD];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rv_reg <= 32'(rng) * 32'd65025;
        end
    end

    assign rd_v[0]   = rv_reg[31:16];
    assign rd_res[0] = '0;

    for (genvar k = 0; k < 8; k++)
    begin : g_red
        lpfc_isqrt_cell #(
            .W (16),
            .B (7 - k)
        ) u_cell (
            .clk     (clk),
            .en      (adv),
            .v_in    (rd_v[k]),
            .res_in  (rd_res[k]),
            .v_out   (rd_v[k+1]),
            .res_out (rd_res[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_line_reg[0] <= rd_res[8][7:0];
            for (int i = 1; i < lpfc_pkg::RED_PAD; i++)
            begin
                red_line_reg[i] <= red_line_reg[i-1];
            end
        end
    end

    // green: 255*range^3 / 2^48
    logic [15:0] rg_reg;
    logic [31:0] r2_reg;
    logic [47:0] r3_reg;
    logic [55:0] g255;
    logic [7:0]  grn_line_reg [lpfc_pkg::GRN_PAD];

    assign g255 = {r3_reg, 8'd0} - 56'(r3_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rg_reg <= rng;
            r2_reg <= 32'(rng) * 32'(rng);
            r3_reg <= 48'(r2_reg) * 48'(rg_reg);
            grn_line_reg[0] <= g255[55:48];
            for (int i = 1; i < lpfc_pkg::GRN_PAD; i++)
            begin
                grn_line_reg[i] <= grn_line_reg[i-1];
            end
        end
    end

    // blue: quarter-wave argument and its square
    logic [lpfc_pkg::T_W-1:0]  t_arg;
    logic [lpfc_pkg::SIDE_W-1:0] bs_side_reg;
    logic [lpfc_pkg::U2_W-1:0] u2_reg;
    logic [29:0]               tsq;

    assign t_arg = rng[14] ? (15'd16384 - 15'(rng[13:0])) : 15'(rng[13:0]);
    assign tsq   = 30'(t_arg) * 30'(t_arg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bs_side_reg <= {rng[15:14], t_arg};
            u2_reg      <= {tsq[28:0], 2'b00};
        end
    end

    // Horner chain, highest coefficient preloaded
    logic signed [lpfc_pkg::ACC_W-1:0] hn_acc  [lpfc_pkg::NUM_HORNER+1];
    logic [lpfc_pkg::U2_W-1:0]         hn_u2   [lpfc_pkg::NUM_HORNER+1];
    logic [lpfc_pkg::SIDE_W-1:0]       hn_side [lpfc_pkg::NUM_HORNER+1];

    assign hn_acc[0]  = $signed(lpfc_pkg::SIN_COEF[4]);
    assign hn_u2[0]   = u2_reg;
    assign hn_side[0] = bs_side_reg;

    for (genvar k = 0; k < lpfc_pkg::NUM_HORNER; k++)
    begin : g_sin
        lpfc_horner_cell #(
            .COEF ($signed(lpfc_pkg::SIN_COEF[3-k]))
        ) u_cell (
            .clk      (clk),
            .en       (adv),
            .acc_in   (hn_acc[k]),
            .u2_in    (hn_u2[k]),
            .side_in  (hn_side[k]),
            .acc_out  (hn_acc[k+1]),
            .u2_out   (hn_u2[k+1]),
            .side_out (hn_side[k+1])
        );
    end

    // final multiply by the argument, then scale, clamp and sign
    logic signed [47:0] ps_reg;
    logic [1:0]         quad_reg;
    logic signed [47:0] s_tr;
    logic signed [33:0] s_q;
    logic [30:0]        s_cl;
    logic [38:0]        mag;
    logic [38:0]        mag_up;
    logic [8:0]         blue_next;
    logic [8:0]         blue_reg;
    logic [lpfc_pkg::SIDE_W-1:0] hs;

    assign hs = hn_side[lpfc_pkg::NUM_HORNER];

    always_comb
    begin
        s_tr = ps_reg[47] ? ((ps_reg + 48'sd16383) >>> 14) : (ps_reg >>> 14);
        s_q  = s_tr[33:0];
        if (s_q < 0)
        begin
            s_cl = '0;
        end
        else if (s_q > 34'sd1073741824)
        begin
            s_cl = 31'd1073741824;
        end
        else
        begin
            s_cl = s_q[30:0];
        end
        mag       = {s_cl, 8'd0} - 39'(s_cl);
        mag_up    = mag + 39'd1073741823;
        blue_next = quad_reg[1] ? (9'd0 - mag_up[38:30]) : mag[38:30];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ps_reg   <= 48'(hn_acc[lpfc_pkg::NUM_HORNER]) * 48'($signed({1'b0, hs[14:0]}));
            quad_reg <= hs[16:15];
            blue_reg <= blue_next;
        end
    end

    // output register
    assign m_tdata = {5'd0, blue_reg, grn_line_reg[lpfc_pkg::GRN_PAD-1],
                      red_line_reg[lpfc_pkg::RED_PAD-1], cr_reg[LAT-1]};
    assign m_tuser = tn_line_reg[lpfc_pkg::TN_LINE-1];

    // flagged points carry black
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[42:18] == 25'd0))
        else $error("too-near point with nonzero color");

    // cube never exceeds square root on [0,1)
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:26] <= m_tdata[25:18]))
        else $error("green above red");

    // a stalled output keeps its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output lost during stall");

    // input ready follows the output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready out of step with output register");

endmodule

### src/lpfc_isqrt_cell.sv
module lpfc_isqrt_cell #(
    parameter int W = 48,
    parameter int B = 0
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] v_in,
    input  logic [W-1:0] res_in,
    output logic [W-1:0] v_out,
    output logic [W-1:0] res_out
);

    localparam logic [W-1:0] BIT_VAL = W'(1) << (2 * B);

    logic [W-1:0] trial;
    logic         take;
    logic [W-1:0] v_next;
    logic [W-1:0] res_next;
    logic [W-1:0] v_reg;
    logic [W-1:0] res_reg;

    // resolve one root bit: subtract the trial when it fits
    always_comb
    begin
        trial = res_in + BIT_VAL;
        take  = (v_in >= trial);
        if (take)
        begin
            v_next   = v_in - trial;
            res_next = (res_in >> 1) + BIT_VAL;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            res_reg <= res_next;
        end
    end

    assign v_out   = v_reg;
    assign res_out = res_reg;

endmodule

### src/lpfc_div_cell.sv
module lpfc_div_cell #(
    parameter int W     = 25,
    parameter int QW    = 17,
    parameter bit SHIFT = 1'b1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [W-1:0]  rem_in,
    input  logic [W-2:0]  den_in,
    input  logic [QW-1:0] q_in,
    output logic [W-1:0]  rem_out,
    output logic [W-2:0]  den_out,
    output logic [QW-1:0] q_out
);

    logic [W-1:0]  part;
    logic          take;
    logic [W-1:0]  rem_next;
    logic [QW-1:0] q_next;
    logic [W-1:0]  rem_reg;
    logic [W-2:0]  den_reg;
    logic [QW-1:0] q_reg;

    // one quotient bit of restoring division
    always_comb
    begin
        part     = SHIFT ? {rem_in[W-2:0], 1'b0} : rem_in;
        take     = (part >= {1'b0, den_in});
        rem_next = take ? (part - {1'b0, den_in}) : part;
        q_next   = {q_in[QW-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            q_reg   <= q_next;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

### src/lpfc_horner_cell.sv
module lpfc_horner_cell #(
    parameter logic signed [31:0] COEF = 32'sd0
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [lpfc_pkg::ACC_W-1:0] acc_in,
    input  logic [lpfc_pkg::U2_W-1:0]        u2_in,
    input  logic [lpfc_pkg::SIDE_W-1:0]      side_in,
    output logic signed [lpfc_pkg::ACC_W-1:0] acc_out,
    output logic [lpfc_pkg::U2_W-1:0]        u2_out,
    output logic [lpfc_pkg::SIDE_W-1:0]      side_out
);

    logic signed [63:0]                 prod_next;
    logic signed [63:0]                 prod_reg;
    logic [lpfc_pkg::U2_W-1:0]          u2_mid_reg;
    logic [lpfc_pkg::SIDE_W-1:0]        side_mid_reg;
    logic signed [63:0]                 quo;
    logic signed [lpfc_pkg::ACC_W-1:0]  acc_next;
    logic signed [lpfc_pkg::ACC_W-1:0]  acc_reg;
    logic [lpfc_pkg::U2_W-1:0]          u2_reg;
    logic [lpfc_pkg::SIDE_W-1:0]        side_reg;

    // first half: multiply accumulator by the squared argument
    assign prod_next = 64'(acc_in) * 64'($signed({1'b0, u2_in}));

    // second half: scale by 2^-30 toward zero, add coefficient
    always_comb
    begin
        quo      = prod_reg[63] ? ((prod_reg + 64'sd1073741823) >>> 30) : (prod_reg >>> 30);
        acc_next = COEF + $signed(quo[lpfc_pkg::ACC_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= prod_next;
            u2_mid_reg   <= u2_in;
            side_mid_reg <= side_in;
            acc_reg      <= acc_next;
            u2_reg       <= u2_mid_reg;
            side_reg     <= side_mid_reg;
        end
    end

    assign acc_out  = acc_reg;
    assign u2_out   = u2_reg;
    assign side_out = side_reg;

endmodule
